[src/swts_pkg.sv]
`timescale 1ns / 1ps

package swts_pkg;

	localparam int TASK_COUNT_DEF   = 16;
	localparam int PERIOD_USEC_DEF  = 32000000;
	localparam int SETUP_MARGIN_DEF = 40;

	localparam int EPOCH_W = 32;
	localparam int USEC_W  = 25;
	localparam int PRIO_W  = 5;
	localparam int MASK_W  = 16;

	localparam logic [EPOCH_W-1:0] EPOCH_INVALID = '1;

	typedef enum logic [1:0] {
		OP_SLEEP  = 2'd0,
		OP_EPOCH  = 2'd1,
		OP_MATCH  = 2'd2,
		OP_STATUS = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [3:0]          task_index;
		logic [EPOCH_W-1:0]  wake_epoch;
		logic [USEC_W-1:0]   wake_usec;
		logic [USEC_W-1:0]   timer_now;
		logic                has_block_object;
		logic                task_enable;
		logic                task_active;
		logic                task_stopped;
		logic [PRIO_W-1:0]   task_priority;
	} cmd_t;

	typedef struct packed {
		logic [USEC_W-1:0]   compare_value;
		logic                task_sleeps;
		logic [MASK_W-1:0]   woken_mask;
		logic                any_priority_woken;
		logic [PRIO_W-1:0]   woken_priority;
	} result_t;

	typedef struct packed {
		logic [EPOCH_W-1:0]  epoch;
		logic [USEC_W-1:0]   usec;
		logic                stopped;
		logic                active;
		logic                enabled;
		logic [PRIO_W-1:0]   prio;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		epoch:   EPOCH_INVALID,
		usec:    '0,
		stopped: 1'b0,
		active:  1'b0,
		enabled: 1'b0,
		prio:    '0
	};

	typedef struct packed {
		logic clear;
		logic eval;
	} scan_ctl_t;

	typedef struct packed {
		logic [USEC_W-1:0]   next;
		logic [MASK_W-1:0]   mask;
		logic                any;
		logic [PRIO_W-1:0]   best;
	} scan_sum_t;

endpackage

[src/sleep_wakeup_timer_scan.sv]
`timescale 1ns / 1ps
// A sleep request or status update steps through the read, modify/write and finish states before done;
// an index out of range goes straight to the finish state.
// Epoch overflow or compare match: the scan state, then the drain and finish states before done,
// one table read per task except task 0, through the single read port.
// A new start is taken in the cycle done is high; the receiver cannot stall results.
// Reset: epoch 0, compare PERIOD_USEC + 1, table entries read as reset until written.

module sleep_wakeup_timer_scan #(
	parameter int TASK_COUNT   = swts_pkg::TASK_COUNT_DEF,
	parameter int PERIOD_USEC  = swts_pkg::PERIOD_USEC_DEF,
	parameter int SETUP_MARGIN = swts_pkg::SETUP_MARGIN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  swts_pkg::cmd_t    item,
	output logic              done,
	output swts_pkg::result_t result
);
	import swts_pkg::*;

	localparam int AW = $clog2(TASK_COUNT);
	localparam int IW = (AW > 4) ? AW : 4;
	localparam logic [USEC_W-1:0] PERIOD_V  = USEC_W'(PERIOD_USEC);
	localparam logic [USEC_W-1:0] PERIOD_P1 = USEC_W'(PERIOD_USEC + 1);
	localparam logic [USEC_W:0]   MARGIN_V  = (USEC_W + 1)'(SETUP_MARGIN);

	state_t             state_q, state_d;
	cmd_t               item_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [USEC_W-1:0]  compare_q;
	logic               sleeps_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      addr_s1;
	logic               eval_s1;
	logic               done_q;
	result_t            result_q;

	logic               accept;
	logic               in_range;
	logic               q_in_range;
	logic [AW-1:0]      idx_addr;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	entry_t             rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;

	entry_t             rmw_entry;
	logic               rmw_sleeps;
	logic               rmw_cmp_en;
	logic               ep_ge;
	logic               ep_eq;
	logic               margin_ok;

	scan_ctl_t          scan_ctl;
	logic               wb_en;
	entry_t             wb_data;
	scan_sum_t          sum;
	logic [USEC_W-1:0]  scan_cmp;
	logic [USEC_W-1:0]  cmp_final;
	logic               is_scan;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign in_range   = {4'b0, item.task_index} < 8'(TASK_COUNT);
	assign q_in_range = {4'b0, item_q.task_index} < 8'(TASK_COUNT);
	assign idx_addr   = AW'(IW'(item_q.task_index));
	assign is_scan    = (item_q.opcode == OP_EPOCH) || (item_q.opcode == OP_MATCH);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.opcode) inside
						OP_SLEEP, OP_STATUS: state_d = in_range ? ST_RMW_RD : ST_FINISH;
						OP_EPOCH, OP_MATCH:  state_d = ST_SCAN;
						default:             state_d = ST_FINISH;
					endcase
				end
			end
			ST_RMW_RD: state_d = ST_RMW_WR;
			ST_RMW_WR: state_d = ST_FINISH;
			ST_SCAN: begin
				if (ptr_q == AW'(TASK_COUNT - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en          = 1'b0;
		rd_addr        = idx_addr;
		wr_en          = 1'b0;
		wr_addr        = idx_addr;
		wr_data        = rmw_entry;
		scan_ctl.clear = accept;
		scan_ctl.eval  = eval_s1;
		unique case (state_q)
			ST_RMW_RD: rd_en = 1'b1;
			ST_RMW_WR: wr_en = 1'b1;
			ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = ptr_q;
				wr_en   = wb_en;
				wr_addr = addr_s1;
				wr_data = wb_data;
			end
			ST_DRAIN: begin
				wr_en   = wb_en;
				wr_addr = addr_s1;
				wr_data = wb_data;
			end
			default: ;
		endcase
	end

	always_comb begin
		ep_ge      = item_q.wake_epoch >= epoch_q;
		ep_eq      = item_q.wake_epoch == epoch_q;
		margin_ok  = {1'b0, item_q.wake_usec} > ({1'b0, item_q.timer_now} + MARGIN_V);
		rmw_entry  = rd_data;
		rmw_sleeps = 1'b0;
		rmw_cmp_en = 1'b0;
		if (item_q.opcode == OP_SLEEP) begin
			if (ep_ge) begin
				rmw_entry.epoch = item_q.wake_epoch;
				rmw_entry.usec  = item_q.wake_usec;
			end
			rmw_cmp_en = ep_ge && ep_eq && margin_ok && (item_q.wake_usec < compare_q);
			rmw_sleeps = (ep_ge && (!ep_eq || margin_ok)) || item_q.has_block_object;
			if (rmw_sleeps) begin
				rmw_entry.active = 1'b0;
			end
		end else begin
			rmw_entry.enabled = item_q.task_enable;
			rmw_entry.active  = item_q.task_active;
			rmw_entry.stopped = item_q.task_stopped;
			rmw_entry.prio    = item_q.task_priority;
		end
	end

	assign scan_cmp  = (sum.next < PERIOD_V) ? sum.next : PERIOD_P1;
	assign cmp_final = is_scan ? scan_cmp : compare_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			epoch_q   <= '0;
			compare_q <= PERIOD_P1;
			sleeps_q  <= 1'b0;
			ptr_q     <= '0;
			eval_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			eval_s1 <= (state_q == ST_SCAN);
			done_q  <= (state_q == ST_FINISH);
			if (accept) begin
				sleeps_q <= 1'b0;
				ptr_q    <= AW'(1);
				if (item.opcode == OP_EPOCH) begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
			if (state_q == ST_SCAN) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (state_q == ST_RMW_WR) begin
				sleeps_q <= rmw_sleeps;
				if (rmw_cmp_en) begin
					compare_q <= item_q.wake_usec;
				end
			end
			if (state_q == ST_FINISH) begin
				compare_q <= cmp_final;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		addr_s1 <= ptr_q;
		if (state_q == ST_FINISH) begin
			result_q.compare_value      <= cmp_final;
			result_q.task_sleeps        <= sleeps_q && q_in_range;
			result_q.woken_mask         <= is_scan ? sum.mask : '0;
			result_q.any_priority_woken <= is_scan && sum.any;
			result_q.woken_priority     <= is_scan ? sum.best : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	swts_table #(
		.DEPTH (TASK_COUNT),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	swts_scan #(
		.TASK_COUNT  (TASK_COUNT),
		.PERIOD_USEC (PERIOD_USEC),
		.AW          (AW)
	) u_scan (
		.clk     (clk),
		.ctl     (scan_ctl),
		.addr    (addr_s1),
		.entry   (rd_data),
		.epoch   (epoch_q),
		.now     (item_q.timer_now),
		.wb_en   (wb_en),
		.wb_data (wb_data),
		.sum     (sum)
	);

endmodule

[src/swts_table.sv]
`timescale 1ns / 1ps

module swts_table #(
	parameter int DEPTH = swts_pkg::TASK_COUNT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output swts_pkg::entry_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  swts_pkg::entry_t wr_data
);
	import swts_pkg::*;

	entry_t           mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	entry_t           data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// entries never written read as their reset contents
	assign rd_data = rd_vld_q ? data_q : ENTRY_RESET;

endmodule

[src/swts_scan.sv]
`timescale 1ns / 1ps

module swts_scan #(
	parameter int TASK_COUNT  = swts_pkg::TASK_COUNT_DEF,
	parameter int PERIOD_USEC = swts_pkg::PERIOD_USEC_DEF,
	parameter int AW          = $clog2(TASK_COUNT)
) (
	input  logic                          clk,
	input  swts_pkg::scan_ctl_t           ctl,
	input  logic [AW-1:0]                 addr,
	input  swts_pkg::entry_t              entry,
	input  logic [swts_pkg::EPOCH_W-1:0]  epoch,
	input  logic [swts_pkg::USEC_W-1:0]   now,
	output logic                          wb_en,
	output swts_pkg::entry_t              wb_data,
	output swts_pkg::scan_sum_t           sum
);
	import swts_pkg::*;

	localparam logic [USEC_W-1:0] PERIOD_V = USEC_W'(PERIOD_USEC);

	scan_sum_t sum_q;
	logic      elig;
	logic      wake;
	logic      pend;
	logic      pick;
	logic [6:0] a7;

	always_comb begin
		elig = entry.enabled && !entry.active && (entry.epoch != EPOCH_INVALID);
		wake = elig && ((entry.epoch < epoch) ||
			((entry.epoch == epoch) && (entry.usec <= now)));
		pend = elig && !wake && (entry.epoch == epoch) && (entry.usec < sum_q.next);
		pick = wake && !entry.stopped && (!sum_q.any || (entry.prio > sum_q.best));
		a7   = 7'(addr);
	end

	always_comb begin
		wb_en          = ctl.eval && wake;
		wb_data        = entry;
		wb_data.epoch  = EPOCH_INVALID;
		wb_data.active = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			sum_q.next <= PERIOD_V;
			sum_q.mask <= '0;
			sum_q.any  <= 1'b0;
			sum_q.best <= '0;
		end else if (ctl.eval) begin
			if (pend) begin
				sum_q.next <= entry.usec;
			end
			if (wake && (a7 < 7'(MASK_W))) begin
				sum_q.mask[a7[3:0]] <= 1'b1;
			end
			if (pick) begin
				sum_q.any  <= 1'b1;
				sum_q.best <= entry.prio;
			end
		end
	end

	assign sum = sum_q;

endmodule

[src/swts_checker.sv]
`timescale 1ns / 1ps

module swts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input swts_pkg::result_t result
);
	import swts_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start transfer");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result transfer");

	a_task0_skip: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !result.woken_mask[0])
		else $error("task 0 reported woken");

	a_prio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.any_priority_woken |-> result.woken_priority == '0)
		else $error("priority reported with no woken task");

	a_sleep_noscan: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.task_sleeps |-> result.woken_mask == '0)
		else $error("sleep result carries a woken mask");

endmodule

bind sleep_wakeup_timer_scan swts_checker u_swts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
